/* sv/sst_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the sparse slot table.
// No dependencies; every other file imports this package.
package sst_pkg;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 31;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;
   localparam int STAT_W  = 3;
   localparam int WORD_W  = VALUE_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_GROW   = 3'd0,
      CMD_ADD    = 3'd1,
      CMD_WRITE  = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_SHRINK = 3'd4,
      CMD_READ   = 3'd5,
      CMD_QUERY  = 3'd6
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 3'd0,
      ST_MISS  = 3'd1,
      ST_RANGE = 3'd2,
      ST_CAP   = 3'd3,
      ST_ZERO  = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic clear_run;
      logic load_item;
      logic issue_idx;
      logic scan_run;
      logic tail_run;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             hit;
      logic             more;
      logic             pend;
      logic             clear_last;
   } dp_sts_type;

endpackage

/* sv/sst_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response words.
// Depends on sst_pkg for field widths.
interface sst_req_if import sst_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] slot_index;
   logic [COUNT_W-1:0] grow_count;

   modport source (output valid, command, value, slot_index, grow_count, input ready);
   modport sink   (input valid, command, value, slot_index, grow_count, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*;;
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [VALUE_W-1:0] read_value;
   logic               read_full;
   logic [COUNT_W-1:0] table_size;
   logic [COUNT_W-1:0] full_count;

   modport source (output valid, status, read_value, read_full, table_size, full_count,
                   input ready);
   modport sink   (input valid, status, read_value, read_full, table_size, full_count,
                   output ready);
endinterface

/* sv/sst_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the slot table: sequences clear, load, issue, scan, tail and finish steps.
// Depends on sst_pkg; drives the datapath in sst_dp through dp_cmd_type.
module sst_ctrl import sst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type ctl,
   input  dp_sts_type sts
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_ISSUE = 6'b000100,
      S_SCAN  = 6'b001000,
      S_TAIL  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      scan_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_end  = !sts.pend && !sts.more;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.clear_run = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_item = 1'b1;
               state_in      = S_ISSUE;
            end
         end
         S_ISSUE: begin
            unique case (sts.cmd) inside
               CMD_WRITE, CMD_READ: begin
                  ctl.issue_idx = 1'b1;
                  state_in      = S_DONE;
               end
               CMD_ADD, CMD_DELETE, CMD_SHRINK: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            ctl.scan_run = 1'b1;
            if (sts.cmd == CMD_SHRINK) begin
               if (scan_end) begin
                  state_in = S_TAIL;
               end
            end else if (sts.hit || scan_end) begin
               state_in = S_DONE;
            end
         end
         S_TAIL: begin
            ctl.tail_run = 1'b1;
            if (!sts.more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (csr_write_en) begin
         state_in = S_CLEAR;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/sst_dp.sv */
`timescale 1ns / 1ps
// Datapath of the slot table: slot memory, size and count, scan pointers, result word.
// Depends on sst_pkg; commanded by sst_ctrl.
module sst_dp import sst_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [COUNT_W-1:0] csr_write_data,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0] req_slot_index,
   input  logic [COUNT_W-1:0] req_grow_count,
   input  dp_cmd_type         ctl,
   output dp_sts_type         sts,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [VALUE_W-1:0] rsp_read_value,
   output logic               rsp_read_full,
   output logic [COUNT_W-1:0] rsp_table_size,
   output logic [COUNT_W-1:0] rsp_full_count
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int SIZE_W = $clog2(CAPACITY + 1);
   localparam int SUM_W  = ((SIZE_W > COUNT_W) ? SIZE_W : COUNT_W) + 1;
   localparam int CMP_W  = (SIZE_W > INDEX_W) ? SIZE_W : INDEX_W;

   // memory word: {full, value}
   logic [WORD_W-1:0] mem [CAPACITY];
   logic [WORD_W-1:0] rd_word_ff;

   logic [SIZE_W-1:0]  used_ff, used_in;
   logic [SIZE_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0]  ptr_ff, ptr_in;
   logic [SIZE_W-1:0]  wptr_ff, wptr_in;
   logic               pend_ff, pend_in;
   logic               found_ff, found_in;
   logic [ADDR_W-1:0]  paddr_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [COUNT_W-1:0] cnt_ff;

   logic [STAT_W-1:0]  status_ff, status_in;
   logic [VALUE_W-1:0] rval_ff, rval_in;
   logic               rfull_ff, rfull_in;
   logic [COUNT_W-1:0] size_res_ff;
   logic [COUNT_W-1:0] count_res_ff;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [WORD_W-1:0]  mem_wdata;

   logic               more, hit, idx_ok, rd_full, shrink_move, scan_end;
   logic [VALUE_W-1:0] rd_val;
   logic [ADDR_W-1:0]  ptr_addr, idx_addr;
   logic [SUM_W-1:0]   grow_sum;
   logic [SIZE_W-1:0]  clamp_size;

   assign rd_full     = rd_word_ff[WORD_W-1];
   assign rd_val      = rd_word_ff[VALUE_W-1:0];
   assign more        = ptr_ff < used_ff;
   assign scan_end    = !pend_ff && !more;
   assign ptr_addr    = ptr_ff[ADDR_W-1:0];
   assign idx_addr    = ADDR_W'(idx_ff);
   assign idx_ok      = CMP_W'(idx_ff) < CMP_W'(used_ff);
   assign grow_sum    = SUM_W'(used_ff) + SUM_W'(cnt_ff);
   assign shrink_move = (cmd_ff == CMD_SHRINK) && pend_ff && rd_full;
   assign hit         = pend_ff &&
                        (((cmd_ff == CMD_ADD) && !rd_full) ||
                         ((cmd_ff == CMD_DELETE) && rd_full && (rd_val == val_ff)));

   assign sts.cmd        = cmd_ff;
   assign sts.hit        = hit;
   assign sts.more       = more;
   assign sts.pend       = pend_ff;
   assign sts.clear_last = (ptr_ff == SIZE_W'(CAPACITY - 1));

   always_comb begin
      if (csr_write_data == '0) begin
         clamp_size = SIZE_W'(1);
      end else if (32'(csr_write_data) > 32'(CAPACITY)) begin
         clamp_size = SIZE_W'(CAPACITY);
      end else begin
         clamp_size = SIZE_W'(csr_write_data);
      end
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_addr;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = ptr_addr;
      if (ctl.clear_run) begin
         mem_we = 1'b1;
      end
      if (ctl.issue_idx) begin
         mem_re    = 1'b1;
         mem_raddr = idx_addr;
      end
      if (ctl.scan_run) begin
         mem_re = more;
         if (hit) begin
            mem_we    = 1'b1;
            mem_waddr = paddr_ff;
            mem_wdata = (cmd_ff == CMD_ADD) ? {1'b1, val_ff} : '0;
         end else if (shrink_move) begin
            mem_we    = 1'b1;
            mem_waddr = wptr_ff[ADDR_W-1:0];
            mem_wdata = rd_word_ff;
         end
      end
      if (ctl.tail_run) begin
         mem_we = more;
      end
      if (ctl.finish) begin
         if ((cmd_ff == CMD_ADD) && !found_ff && (used_ff < SIZE_W'(CAPACITY))) begin
            mem_we    = 1'b1;
            mem_waddr = used_ff[ADDR_W-1:0];
            mem_wdata = {1'b1, val_ff};
         end else if ((cmd_ff == CMD_WRITE) && idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = idx_addr;
            mem_wdata = {1'b1, val_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= mem[mem_raddr];
      end
   end

   // result of the finishing step
   always_comb begin
      status_in = ST_OK;
      rval_in   = '0;
      rfull_in  = 1'b0;
      used_in   = used_ff;
      count_in  = count_ff;
      case (cmd_ff)
         CMD_GROW: begin
            if (cnt_ff == '0) begin
               status_in = ST_ZERO;
            end else if (grow_sum > SUM_W'(CAPACITY)) begin
               status_in = ST_CAP;
            end else begin
               used_in = SIZE_W'(grow_sum);
            end
         end
         CMD_ADD: begin
            if (found_ff) begin
               count_in = count_ff + SIZE_W'(1);
            end else if (used_ff >= SIZE_W'(CAPACITY)) begin
               status_in = ST_CAP;
            end else begin
               used_in  = used_ff + SIZE_W'(1);
               count_in = count_ff + SIZE_W'(1);
            end
         end
         CMD_WRITE: begin
            if (!idx_ok) begin
               status_in = ST_RANGE;
            end else if (!rd_full) begin
               count_in = count_ff + SIZE_W'(1);
            end
         end
         CMD_DELETE: begin
            if (found_ff) begin
               count_in = count_ff - SIZE_W'(1);
            end else begin
               status_in = ST_MISS;
            end
         end
         CMD_SHRINK: begin
            used_in  = wptr_ff;
            count_in = wptr_ff;
         end
         CMD_READ: begin
            if (!idx_ok) begin
               status_in = ST_RANGE;
            end else begin
               rfull_in = rd_full;
               rval_in  = rd_full ? rd_val : '0;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // pointer and flag next values
   always_comb begin
      ptr_in   = ptr_ff;
      wptr_in  = wptr_ff;
      pend_in  = pend_ff;
      found_in = found_ff;
      if (ctl.load_item) begin
         ptr_in   = '0;
         wptr_in  = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end
      if (ctl.clear_run) begin
         ptr_in = ptr_ff + SIZE_W'(1);
      end
      if (ctl.scan_run) begin
         pend_in = more;
         if (more) begin
            ptr_in = ptr_ff + SIZE_W'(1);
         end
         if (hit) begin
            found_in = 1'b1;
         end
         if (shrink_move) begin
            wptr_in = wptr_ff + SIZE_W'(1);
         end
         if ((cmd_ff == CMD_SHRINK) && scan_end) begin
            ptr_in = wptr_ff;
         end
      end
      if (ctl.tail_run && more) begin
         ptr_in = ptr_ff + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= SIZE_W'(1);
         count_ff <= '0;
         ptr_ff   <= '0;
         wptr_ff  <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else if (csr_write_en) begin
         used_ff  <= clamp_size;
         count_ff <= '0;
         ptr_ff   <= '0;
         wptr_ff  <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         wptr_ff  <= wptr_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         if (ctl.finish) begin
            used_ff  <= used_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
         idx_ff <= req_slot_index;
         cnt_ff <= req_grow_count;
      end
      if (ctl.scan_run) begin
         paddr_ff <= ptr_addr;
      end
      if (ctl.finish) begin
         status_ff    <= status_in;
         rval_ff      <= rval_in;
         rfull_ff     <= rfull_in;
         size_res_ff  <= COUNT_W'(used_in);
         count_res_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_read_full  = rfull_ff;
   assign rsp_table_size = size_res_ff;
   assign rsp_full_count = count_res_ff;

endmodule

/* sv/sparse_slot_table_unit.sv */
`timescale 1ns / 1ps
// Top level of the sparse slot table: controller plus datapath.
// Depends on sst_pkg, sst_ifs (sst_req_if, sst_rsp_if), sst_ctrl and sst_dp.
//
//  channel   dir  handshake             word
//  req_ch    in   valid/ready           command, value, slot_index, grow_count
//  rsp_ch    out  valid/ready           status, read_value, read_full, table_size, full_count
//  csr_*     in   csr_write_en (no wait) csr_write_data = start_size
//
// One word at a time. Add and delete scan the table one slot a cycle through the single
// memory read port, and shrink makes a compaction walk, then a tail walk that empties
// the freed slots. After reset and after every csr write a clearing pass empties the
// slot memory; req_ch.ready stays low during it.
// A finished word waits in the output register; a stalled rsp_ch holds the next
// word in its finishing step until the register frees up.
module sparse_slot_table_unit import sst_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   sst_req_if.sink            req_ch,
   sst_rsp_if.source          rsp_ch,
   input  logic               csr_write_en,
   input  logic [COUNT_W-1:0] csr_write_data
);

   dp_cmd_type ctl;
   dp_sts_type sts;

   // sequence the steps of each word
   sst_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .ctl          (ctl),
      .sts          (sts)
   );

   // hold the table, walk it and build the response word
   sst_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_command    (req_ch.command),
      .req_value      (req_ch.value),
      .req_slot_index (req_ch.slot_index),
      .req_grow_count (req_ch.grow_count),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_status     (rsp_ch.status),
      .rsp_read_value (rsp_ch.read_value),
      .rsp_read_full  (rsp_ch.read_full),
      .rsp_table_size (rsp_ch.table_size),
      .rsp_full_count (rsp_ch.full_count)
   );

   // a word in work blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while a word is in work");

   // reset and csr writes start the clearing pass
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request taken before the clearing pass");

   a_clear_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ch.ready)
      else $error("request taken right after a csr write");

   // the datapath sees at most one step per cycle
   a_one_step: assert property (@(posedge clock) $onehot0(ctl))
      else $error("controller issued overlapping datapath steps");

endmodule

/* dv/tb_sparse_slot_table_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench of sparse_slot_table_unit: directed rows, then random phases.
// Depends on sst_pkg, sst_ifs and the sparse_slot_table_unit RTL.
module tb_sparse_slot_table_unit;
   import sst_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int LONG_HOLD     = 1500;
   localparam int TAIL_CYCLES   = 600;
   localparam int RANDOM_START  = -1;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASES        = 5;

   // command code outside the enum; the block treats it as a query
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] idx;
      logic [COUNT_W-1:0] count;
   } table_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] rval;
      logic               rfull;
      logic [COUNT_W-1:0] size;
      logic [COUNT_W-1:0] fill;
   } table_rsp_type;

   // typed rows carry status, size and fill; read_value and read_full are zero on them
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] idx;
      logic [COUNT_W-1:0] count;
      logic               typed;
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] size;
      logic [COUNT_W-1:0] fill;
   } directed_row_type;

   typedef struct packed {
      int start;
      int sender_pct;
      int recv_pct;
      int words;
      bit fill_mode;
      int hold_at;
      int pause_at;
   } phase_plan_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_en;
   logic [COUNT_W-1:0] csr_write_data;

   sst_req_if req_bus ();
   sst_rsp_if rsp_bus ();

   // shadow copy of the table, advanced once per accepted request word
   logic [VALUE_W-1:0] shadow_value [TABLE_DEPTH];
   bit                 shadow_full  [TABLE_DEPTH];
   int                 shadow_size;
   int                 shadow_fill;

   table_rsp_type awaited_words [$];
   int            fault_count = 0;
   int            sender_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_pending = 1'b0;
   int            hold_left = 0;

   // after reset: start size 1, one empty slot
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_QUERY,  31'd0,          8'd0,   9'd0,   1'b1, ST_OK,    9'd1,   9'd0},
      '{CMD_READ,   31'd0,          8'd0,   9'd0,   1'b1, ST_OK,    9'd1,   9'd0},
      '{CMD_READ,   31'd0,          8'd255, 9'd0,   1'b1, ST_RANGE, 9'd1,   9'd0},
      '{CMD_WRITE,  31'h7FFFFFFF,   8'd1,   9'd0,   1'b1, ST_RANGE, 9'd1,   9'd0},
      '{CMD_GROW,   31'd0,          8'd0,   9'd0,   1'b1, ST_ZERO,  9'd1,   9'd0},
      '{CMD_GROW,   31'd0,          8'd0,   9'd256, 1'b1, ST_CAP,   9'd1,   9'd0},
      '{CMD_GROW,   31'd0,          8'd0,   9'd511, 1'b1, ST_CAP,   9'd1,   9'd0},
      '{CMD_GROW,   31'd0,          8'd0,   9'd255, 1'b1, ST_OK,    9'd256, 9'd0},
      '{CMD_ADD,    31'h7FFFFFFF,   8'd0,   9'd0,   1'b1, ST_OK,    9'd256, 9'd1},
      '{CMD_WRITE,  31'd0,          8'd255, 9'd0,   1'b1, ST_OK,    9'd256, 9'd2},
      '{CMD_WRITE,  31'h2AAAAAAA,   8'd255, 9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_READ,   31'd0,          8'd255, 9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_READ,   31'd0,          8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_DELETE, 31'h12345,      8'd0,   9'd0,   1'b1, ST_MISS,  9'd256, 9'd2},
      '{CMD_DELETE, 31'h7FFFFFFF,   8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_ADD,    31'h55555555,   8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_SHRINK, 31'd0,          8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_READ,   31'd0,          8'd1,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_READ,   31'd0,          8'd2,   9'd0,   1'b1, ST_RANGE, 9'd2,   9'd2},
      '{CMD_SPARE,  31'h7FFFFFFF,   8'd255, 9'd511, 1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_DELETE, 31'h55555555,   8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_DELETE, 31'h2AAAAAAA,   8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_SHRINK, 31'd0,          8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0},
      '{CMD_READ,   31'd0,          8'd0,   9'd0,   1'b1, ST_RANGE, 9'd0,   9'd0},
      '{CMD_ADD,    31'd0,          8'd0,   9'd0,   1'b0, ST_OK,    9'd0,   9'd0}
   };

   // start, sender idle %, receiver stall %, words, fill mode, long hold at, pause at
   phase_plan_type phase_plan [PHASES] = '{
      '{0,            0,  0,  120, 1'b0, 20, -1},
      '{256,          67, 0,  330, 1'b1, -1, -1},
      '{511,          0,  67, 130, 1'b0, -1, 60},
      '{RANDOM_START, 7,  7,  130, 1'b0, -1, -1},
      '{257,          0,  0,  130, 1'b0, -1, -1}
   };

   sparse_slot_table_unit #(
      .CAPACITY(TABLE_DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_bus),
      .rsp_ch        (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Empty the shadow table and reload the size, as the block does after reset or a csr write.
   function automatic void clear_shadow(input int start);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_value[i] = '0;
         shadow_full[i]  = 1'b0;
      end
      shadow_size  = start;
      shadow_fill  = 0;
   endfunction

   // Apply one request word to the shadow table and return the response word it yields.
   function automatic table_rsp_type advance_table(input table_req_type w);
      table_rsp_type r;
      int            wr;
      bit            placed;
      r        = '0;
      r.status = ST_OK;
      case (w.cmd)
         CMD_GROW: begin
            if (w.count == 0) begin
               r.status = ST_ZERO;
            end else if (shadow_size + int'(w.count) > TABLE_DEPTH) begin
               r.status = ST_CAP;
            end else begin
               for (int i = shadow_size; i < shadow_size + int'(w.count); i++) begin
                  shadow_full[i]  = 1'b0;
                  shadow_value[i] = '0;
               end
               shadow_size += int'(w.count);
            end
         end
         CMD_ADD: begin
            placed = 1'b0;
            for (int i = 0; i < shadow_size && !placed; i++) begin
               if (!shadow_full[i]) begin
                  shadow_value[i] = w.value;
                  shadow_full[i]  = 1'b1;
                  shadow_fill++;
                  placed = 1'b1;
               end
            end
            // no hole: append a slot unless the table is at capacity
            if (!placed) begin
               if (shadow_size >= TABLE_DEPTH) begin
                  r.status = ST_CAP;
               end else begin
                  shadow_value[shadow_size] = w.value;
                  shadow_full[shadow_size]  = 1'b1;
                  shadow_size++;
                  shadow_fill++;
               end
            end
         end
         CMD_WRITE: begin
            if (int'(w.idx) >= shadow_size) begin
               r.status = ST_RANGE;
            end else begin
               if (!shadow_full[w.idx]) shadow_fill++;
               shadow_value[w.idx] = w.value;
               shadow_full[w.idx]  = 1'b1;
            end
         end
         CMD_DELETE: begin
            r.status = ST_MISS;
            for (int i = 0; i < shadow_size && r.status == ST_MISS; i++) begin
               if (shadow_full[i] && shadow_value[i] == w.value) begin
                  shadow_full[i] = 1'b0;
                  shadow_fill--;
                  r.status = ST_OK;
               end
            end
         end
         CMD_SHRINK: begin
            // compact in order, then empty everything past the last kept slot
            wr = 0;
            for (int i = 0; i < shadow_size; i++) begin
               if (shadow_full[i]) begin
                  shadow_value[wr] = shadow_value[i];
                  shadow_full[wr]  = 1'b1;
                  wr++;
               end
            end
            for (int i = wr; i < shadow_size; i++) shadow_full[i] = 1'b0;
            shadow_size = wr;
            shadow_fill = wr;
         end
         CMD_READ: begin
            if (int'(w.idx) >= shadow_size) begin
               r.status = ST_RANGE;
            end else if (shadow_full[w.idx]) begin
               r.rval  = shadow_value[w.idx];
               r.rfull = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.size = shadow_size[COUNT_W-1:0];
      r.fill = shadow_fill[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] draw_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return VALUE_W'($urandom());
      if (pick < 75) return VALUE_W'($urandom_range(15));
      if (pick < 87) return '1;
      return '0;
   endfunction

   // Draw a random request word, steered by the shadow table so most words do real work.
   function automatic table_req_type draw_word(input bit fill_mode);
      table_req_type w;
      int            pick;
      int            slot;
      w.value = draw_value();
      w.idx   = INDEX_W'($urandom_range(255));
      w.count = COUNT_W'($urandom_range(511));
      pick    = $urandom_range(99);
      if (fill_mode) begin
         if (pick < 80)      w.cmd = CMD_ADD;
         else if (pick < 90) w.cmd = CMD_WRITE;
         else if (pick < 97) w.cmd = CMD_READ;
         else                w.cmd = CMD_QUERY;
      end else begin
         if (pick < 10)      w.cmd = CMD_GROW;
         else if (pick < 32) w.cmd = CMD_ADD;
         else if (pick < 47) w.cmd = CMD_WRITE;
         else if (pick < 67) w.cmd = CMD_DELETE;
         else if (pick < 73) w.cmd = CMD_SHRINK;
         else if (pick < 90) w.cmd = CMD_READ;
         else if (pick < 96) w.cmd = CMD_QUERY;
         else                w.cmd = CMD_SPARE;
      end
      case (w.cmd)
         CMD_WRITE, CMD_READ: begin
            if (shadow_size > 0 && $urandom_range(99) < 85)
               w.idx = INDEX_W'($urandom_range(shadow_size - 1));
         end
         CMD_DELETE: begin
            // pick a stored value most of the time so deletes hit
            if (shadow_size > 0 && $urandom_range(99) < 60) begin
               slot = $urandom_range(shadow_size - 1);
               if (shadow_full[slot]) w.value = shadow_value[slot];
            end
         end
         CMD_GROW: begin
            pick = $urandom_range(99);
            if (pick < 60)
               w.count = COUNT_W'($urandom_range(8, 1));
            else if (pick < 75)
               w.count = '0;
            else if (pick >= 90 && shadow_size < TABLE_DEPTH)
               w.count = COUNT_W'(TABLE_DEPTH - shadow_size);
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // Offer one word after a random idle stretch; hold it until accepted, then predict.
   task automatic offer_word(input table_req_type w, input bit typed,
                             input table_rsp_type typed_rsp);
      table_rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= w.cmd;
      req_bus.value      <= w.value;
      req_bus.slot_index <= w.idx;
      req_bus.grow_count <= w.count;
      do @(posedge clock); while (!req_bus.ready);
      predicted = advance_table(w);
      awaited_words.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // Drop valid and wait until every awaited response word has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the start size while idle and mirror the clamped value in the shadow table.
   task automatic load_start_size(input logic [COUNT_W-1:0] start);
      int clamped;
      clamped = int'(start);
      if (clamped < 1) clamped = 1;
      if (clamped > TABLE_DEPTH) clamped = TABLE_DEPTH;
      csr_write_en   <= 1'b1;
      csr_write_data <= start;
      clear_shadow(clamped);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic note_fault(input string what, input table_rsp_type want,
                             input table_rsp_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%0t %s: expected st=%0d rv=%h rf=%0d sz=%0d fc=%0d",
                  $realtime, what, want.status, want.rval, want.rfull, want.size, want.fill);
         $display("   got st=%0d rv=%h rf=%0d sz=%0d fc=%0d",
                  got.status, got.rval, got.rfull, got.size, got.fill);
      end
   endtask

   // Drive ready at the falling edge; a long hold request overrides the random stalls.
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left    = LONG_HOLD;
         hold_pending = 1'b0;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sample the response channel at the rising edge and check against the oldest expectation.
   always @(posedge clock) begin
      table_rsp_type got;
      table_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status = rsp_bus.status;
         got.rval   = rsp_bus.read_value;
         got.rfull  = rsp_bus.read_full;
         got.size   = rsp_bus.table_size;
         got.fill   = rsp_bus.full_count;
         if (awaited_words.size() == 0) begin
            note_fault("unexpected word", '0, got);
         end else begin
            want = awaited_words.pop_front();
            if (got.status !== want.status || got.rval !== want.rval ||
                got.rfull !== want.rfull || got.size !== want.size || got.fill !== want.fill)
               note_fault("mismatch", want, got);
         end
      end
   end

   initial begin
      table_req_type w;
      table_rsp_type typed_rsp;
      logic [COUNT_W-1:0] start;

      // hold every input at a known value from time zero
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.command    = '0;
      req_bus.value      = '0;
      req_bus.slot_index = '0;
      req_bus.grow_count = '0;
      rsp_bus.ready      = 1'b0;
      clear_shadow(1);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // walk the directed rows with no idling; typed rows carry their own expectation
      foreach (directed_rows[i]) begin
         w.cmd            = directed_rows[i].cmd;
         w.value          = directed_rows[i].value;
         w.idx            = directed_rows[i].idx;
         w.count          = directed_rows[i].count;
         typed_rsp        = '0;
         typed_rsp.status = directed_rows[i].status;
         typed_rsp.size   = directed_rows[i].size;
         typed_rsp.fill   = directed_rows[i].fill;
         offer_word(w, directed_rows[i].typed, typed_rsp);
      end

      foreach (phase_plan[p]) begin
         drain_responses();
         if (phase_plan[p].start == RANDOM_START)
            start = COUNT_W'($urandom_range(511));
         else
            start = COUNT_W'(phase_plan[p].start);
         load_start_size(start);
         sender_idle_pct = phase_plan[p].sender_pct;
         recv_stall_pct  = phase_plan[p].recv_pct;
         for (int n = 0; n < phase_plan[p].words; n++) begin
            // stall the receiver for a long stretch while words keep coming
            if (n == phase_plan[p].hold_at) hold_pending = 1'b1;
            // pause the sender until the block has answered everything
            if (n == phase_plan[p].pause_at) drain_responses();
            offer_word(draw_word(phase_plan[p].fill_mode), 1'b0, '0);
         end
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("PASS sparse_slot_table_unit");
      else
         $display("FAIL sparse_slot_table_unit");
      $finish;
   end

   // bound the run well past the slowest legal schedule
   initial begin
      #30_000_000;
      $display("FAIL sparse_slot_table_unit");
      $finish;
   end

endmodule
